### design/tbdc_pkg.sv
// ----------------------------------------------------------------------------
// tbdc_pkg
// Shared types, codes and sizes of the two barrier direction counter.
// ----------------------------------------------------------------------------
package tbdc_pkg;

   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 8;

   localparam int CMD_BITS   = 2;
   localparam int STAMP_BITS = 32;
   localparam int DEB_BITS   = 8;
   localparam int TMO_BITS   = 16;
   localparam int OCC_BITS   = 8;
   localparam int CS_BITS    = 2;
   localparam int EV_BITS    = 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // input command codes
   localparam logic [CMD_BITS-1:0] CMD_INNER = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_OUTER = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT  = 2'd1;

   localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = 8'd5;
   localparam logic [TMO_BITS-1:0] TIMEOUT_RESET  = 16'd1000;

   // crossing state codes on the result
   localparam logic [CS_BITS-1:0] CS_IDLE   = 2'd0;
   localparam logic [CS_BITS-1:0] CS_FIRST  = 2'd1;
   localparam logic [CS_BITS-1:0] CS_BOTH   = 2'd2;
   localparam logic [CS_BITS-1:0] CS_SECOND = 2'd3;

   // count event codes
   localparam logic [EV_BITS-1:0] EV_NONE = 2'd0;
   localparam logic [EV_BITS-1:0] EV_INC  = 2'd1;
   localparam logic [EV_BITS-1:0] EV_DEC  = 2'd2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam int WORK_DEPTH = 2;
   localparam int RSP_DEPTH  = 2;
   localparam int WORK_PTR_BITS = $clog2(WORK_DEPTH);
   localparam int RSP_PTR_BITS  = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [STAMP_BITS-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic                  accepted;
      logic                  timed_out;
      logic [CS_BITS-1:0]    crossing_state;
      logic                  entered_inner_first;
      logic [OCC_BITS-1:0]   occupancy;
      logic [EV_BITS-1:0]    count_event;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_INNER = 2'd0,
      OP_OUTER = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [TIME_BITS-1:0] now;
   } work_type;

   typedef struct packed {
      logic [DEB_BITS-1:0] debounce_ms;
      logic [TMO_BITS-1:0] timeout_ms;
   } cfg_type;

   typedef enum logic [3:0] {
      TRK_IDLE   = 4'b0001,
      TRK_FIRST  = 4'b0010,
      TRK_BOTH   = 4'b0100,
      TRK_SECOND = 4'b1000
   } trk_type;

   function automatic logic [CS_BITS-1:0] trk_code(input trk_type trk);
      logic [CS_BITS-1:0] code;
      case (trk)
         TRK_FIRST:  code = CS_FIRST;
         TRK_BOTH:   code = CS_BOTH;
         TRK_SECOND: code = CS_SECOND;
         default:    code = CS_IDLE;
      endcase
      return code;
   endfunction

endpackage

### design/tbdc_front.sv
// ----------------------------------------------------------------------------
// tbdc_front
// Input stage: takes request words, decodes the command and registers it.
// ----------------------------------------------------------------------------
module tbdc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  tbdc_pkg::req_type  req_data,
   output logic               work_valid,
   input  logic               work_ready,
   output tbdc_pkg::work_type work_data
);
   import tbdc_pkg::*;

   logic     valid_ff, valid_in;
   work_type work_ff, work_in;
   logic     take;
   op_type   op;

   always_comb begin
      case (req_data.cmd)
         CMD_INNER: op = OP_INNER;
         CMD_OUTER: op = OP_OUTER;
         CMD_CLEAR: op = OP_CLEAR;
         default:   op = OP_NOP;
      endcase
   end

   assign req_full = valid_ff && !work_ready;
   assign take     = req_push && !req_full;
   assign valid_in = take || (valid_ff && !work_ready);

   always_comb begin
      work_in = work_ff;
      if (take) begin
         work_in.op  = op;
         work_in.now = TIME_BITS'(req_data.time_ms);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      work_ff <= work_in;
   end

   assign work_valid = valid_ff;
   assign work_data  = work_ff;

endmodule

### design/tbdc_queue.sv
// ----------------------------------------------------------------------------
// tbdc_queue
// Short queue of decoded words between the front and back parts.
// ----------------------------------------------------------------------------
module tbdc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tbdc_pkg::work_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tbdc_pkg::work_type pop_data
);
   import tbdc_pkg::*;

   work_type                 slot_ff [WORK_DEPTH];
   logic [WORK_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [WORK_PTR_BITS:0]   cnt_ff, cnt_in;
   logic                     do_push, do_pop;

   assign push_ready = cnt_ff != (WORK_PTR_BITS+1)'(WORK_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == WORK_PTR_BITS'(WORK_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == WORK_PTR_BITS'(WORK_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### design/tbdc_back.sv
// ----------------------------------------------------------------------------
// tbdc_back
// Debounce, timeout, crossing tracker and people count, with result queue.
// ----------------------------------------------------------------------------
module tbdc_back (
   input  logic               clock,
   input  logic               reset,
   input  tbdc_pkg::cfg_type  cfg,
   input  logic               work_valid,
   output logic               work_ready,
   input  tbdc_pkg::work_type work_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output tbdc_pkg::rsp_type  rsp_data
);
   import tbdc_pkg::*;

   trk_type               trk_ff, trk_in;
   logic                  flag_ff, flag_in;
   logic                  in_lvl_ff, in_lvl_in;
   logic                  out_lvl_ff, out_lvl_in;
   logic [TIME_BITS-1:0]  last_in_ff, last_in_in;
   logic [TIME_BITS-1:0]  last_out_ff, last_out_in;
   logic [TIME_BITS-1:0]  last_any_ff, last_any_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   rsp_type               rq_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [RSP_PTR_BITS:0]   cnt_ff, cnt_in;

   logic                  step;
   logic                  is_edge, is_inner;
   logic [TIME_BITS-1:0]  deb_gap, tmo_gap;
   logic                  deb_ok, tmo_hit;
   logic                  level, this_first;
   logic                  acc, tmo;
   logic [EV_BITS-1:0]    ev;
   rsp_type               rsp_new;
   logic                  do_pop;

   assign do_pop     = rsp_pop && !rsp_empty;
   assign work_ready = (cnt_ff != (RSP_PTR_BITS+1)'(RSP_DEPTH)) || do_pop;
   assign step       = work_valid && work_ready;

   assign is_inner = work_data.op == OP_INNER;
   assign is_edge  = is_inner || (work_data.op == OP_OUTER);
   // gaps wrap modulo the time width
   assign deb_gap  = work_data.now - (is_inner ? last_in_ff : last_out_ff);
   assign tmo_gap  = work_data.now - last_any_ff;
   assign deb_ok   = deb_gap > TIME_BITS'(cfg.debounce_ms);
   assign tmo_hit  = tmo_gap > TIME_BITS'(cfg.timeout_ms);

   always_comb begin
      trk_in      = trk_ff;
      flag_in     = flag_ff;
      in_lvl_in   = in_lvl_ff;
      out_lvl_in  = out_lvl_ff;
      last_in_in  = last_in_ff;
      last_out_in = last_out_ff;
      last_any_in = last_any_ff;
      count_in    = count_ff;
      acc         = 1'b0;
      tmo         = 1'b0;
      ev          = EV_NONE;
      level       = 1'b0;
      this_first  = 1'b0;
      if (is_edge && deb_ok) begin
         acc = 1'b1;
         if (tmo_hit) begin
            tmo        = 1'b1;
            trk_in     = TRK_IDLE;
            in_lvl_in  = 1'b0;
            out_lvl_in = 1'b0;
         end
         if (is_inner) begin
            in_lvl_in  = !in_lvl_in;
            level      = in_lvl_in;
            last_in_in = work_data.now;
         end else begin
            out_lvl_in  = !out_lvl_in;
            level       = out_lvl_in;
            last_out_in = work_data.now;
         end
         last_any_in = work_data.now;
         this_first  = flag_ff == is_inner;
         if (level) begin
            case (trk_in)
               TRK_IDLE: begin
                  trk_in  = TRK_FIRST;
                  flag_in = is_inner;
               end
               TRK_FIRST: begin
                  if (!this_first) trk_in = TRK_BOTH;
               end
               TRK_SECOND: begin
                  if (this_first) trk_in = TRK_BOTH;
               end
               default: ;
            endcase
         end else begin
            case (trk_in)
               TRK_BOTH: begin
                  trk_in = this_first ? TRK_SECOND : TRK_FIRST;
               end
               TRK_SECOND: begin
                  if (!this_first) begin
                     trk_in = TRK_IDLE;
                     if (is_inner) begin
                        if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
                        ev = EV_INC;
                     end else begin
                        if (count_ff != '0) count_in = count_ff - 1'b1;
                        ev = EV_DEC;
                     end
                  end
               end
               TRK_FIRST: begin
                  if (this_first) trk_in = TRK_IDLE;
               end
               default: ;
            endcase
         end
      end else if (work_data.op == OP_CLEAR) begin
         count_in = '0;
      end
   end

   always_comb begin
      rsp_new.accepted            = acc;
      rsp_new.timed_out           = tmo;
      rsp_new.crossing_state      = trk_code(trk_in);
      rsp_new.entered_inner_first = flag_in;
      rsp_new.occupancy           = OCC_BITS'(count_in);
      rsp_new.count_event         = ev;
   end

   // result queue
   assign rsp_empty = cnt_ff == '0;
   assign rsp_data  = rq_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (step) begin
         wr_in = (wr_ff == RSP_PTR_BITS'(RSP_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == RSP_PTR_BITS'(RSP_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (step && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !step) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_ff      <= TRK_IDLE;
         flag_ff     <= 1'b1;
         in_lvl_ff   <= 1'b0;
         out_lvl_ff  <= 1'b0;
         last_in_ff  <= '0;
         last_out_ff <= '0;
         last_any_ff <= '0;
         count_ff    <= '0;
         wr_ff       <= '0;
         rd_ff       <= '0;
         cnt_ff      <= '0;
      end else begin
         if (step) begin
            trk_ff      <= trk_in;
            flag_ff     <= flag_in;
            in_lvl_ff   <= in_lvl_in;
            out_lvl_ff  <= out_lvl_in;
            last_in_ff  <= last_in_in;
            last_out_ff <= last_out_in;
            last_any_ff <= last_any_in;
            count_ff    <= count_in;
         end
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (step) begin
         rq_ff[wr_ff] <= rsp_new;
      end
   end

endmodule

### design/two_barrier_direction_counter.sv
// ----------------------------------------------------------------------------
// two_barrier_direction_counter
// Bidirectional people counter driven by inner and outer light barrier edges.
// ----------------------------------------------------------------------------
// Requests: a word (command, ms timestamp) is taken when req_push is high and
// req_full is low. Commands are inner edge, outer edge and clear count.
// Results: one word per request, in order, on rsp_data while rsp_empty is low;
// rsp_pop takes it.
// Registers: csr_index 0 is the debounce time, 1 the tracker timeout; csr_ready
// is always high. Write them only while no request is in flight.
// Path: a request passes the input register and the work queue, then the tracker
// step writes its result into the result queue, whose entry drives rsp_data.
// Throughput: one request per cycle while results are popped; the tracker and
// count update in a single step per word, so the loop through that state sets the rate.
// Reset: tracker idle, both levels low, inner-first flag set, stored times and
// count zero, debounce 5 ms, timeout 1000 ms, both queues empty.
// Stall: while rsp_pop is low the two-entry result queue fills, the tracker
// stops, the work queue fills and req_full rises; nothing is lost.
// ----------------------------------------------------------------------------
module two_barrier_direction_counter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  tbdc_pkg::req_type                     req_data,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output tbdc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tbdc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tbdc_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import tbdc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     fq_valid, fq_ready, qb_valid, qb_ready;
   work_type fq_data, qb_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ms = DEB_BITS'(csr_data);
            CSR_TIMEOUT:  cfg_in.timeout_ms  = TMO_BITS'(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= DEBOUNCE_RESET;
         cfg_ff.timeout_ms  <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tbdc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .work_valid (fq_valid),
      .work_ready (fq_ready),
      .work_data  (fq_data)
   );

   tbdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   tbdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (qb_valid),
      .work_ready (qb_ready),
      .work_data  (qb_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
